### src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

### src/prsu_pkg.sv
// ----------------------------------------------------------------------------
// prsu_pkg
// Types and fixed field widths of the point radius suppression unit.
// ----------------------------------------------------------------------------
package prsu_pkg;

   localparam int COORD_BITS   = 16;
   localparam int STR_BITS     = 16;
   localparam int IDX_BITS     = 8;
   localparam int TOTAL_BITS   = 9;
   localparam int VERDICT_BITS = 3;
   localparam int ENTRY_BITS   = 2 * COORD_BITS + STR_BITS;
   localparam int SQ_BITS      = 2 * COORD_BITS;

   // Request stream packing.
   localparam int REQ_DATA_BITS = 56;
   localparam int REQ_USER_BITS = 2;
   localparam int REQ_X_LSB     = 0;
   localparam int REQ_Y_LSB     = REQ_X_LSB + COORD_BITS;
   localparam int REQ_S_LSB     = REQ_Y_LSB + COORD_BITS;
   localparam int REQ_IDX_LSB   = REQ_S_LSB + STR_BITS;
   localparam int REQ_FUNC_BIT  = 0;
   localparam int REQ_START_BIT = 1;

   // Response stream packing.
   localparam int RSP_DATA_BITS = 72;
   localparam int RSP_USER_BITS = VERDICT_BITS;
   localparam int RSP_SLOT_LSB  = 0;
   localparam int RSP_TOTAL_LSB = RSP_SLOT_LSB + IDX_BITS;
   localparam int RSP_X_LSB     = RSP_TOTAL_LSB + TOTAL_BITS;
   localparam int RSP_S_MSB     = RSP_X_LSB + 2 * COORD_BITS + STR_BITS - 1;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - (RSP_S_MSB + 1);

   // Configuration port.
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RADIUS = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_KEEP   = 1'b1;

   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [VERDICT_BITS-1:0] {
      VERDICT_APPENDED   = 3'd0,
      VERDICT_SUPPRESSED = 3'd1,
      VERDICT_REPLACED   = 3'd2,
      VERDICT_FULL       = 3'd3,
      VERDICT_READ       = 3'd4
   } prsu_verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ,
      ST_SCAN,
      ST_APPEND,
      ST_DECIDE,
      ST_DONE
   } prsu_state_type;

   // Status of the distance compare pipeline.
   typedef struct packed {
      logic hit;
      logic busy;
   } prsu_dist_stat_type;

endpackage

### src/prsu_ram.sv
// ----------------------------------------------------------------------------
// prsu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module prsu_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/prsu_dist.sv
// ----------------------------------------------------------------------------
// prsu_dist
// Two-stage squared-distance compare of the offered point against one stored
// entry per cycle.
// ----------------------------------------------------------------------------
module prsu_dist #(
   parameter int AW = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               flush,
   input  logic                               in_valid,
   input  logic [AW-1:0]                      in_idx,
   input  logic [prsu_pkg::ENTRY_BITS-1:0]    in_entry,
   input  logic [prsu_pkg::COORD_BITS-1:0]    pos_x,
   input  logic [prsu_pkg::COORD_BITS-1:0]    pos_y,
   input  logic [prsu_pkg::SQ_BITS-1:0]       radius_sq,
   output prsu_pkg::prsu_dist_stat_type       stat,
   output logic [AW-1:0]                      hit_idx,
   output logic [prsu_pkg::STR_BITS-1:0]      hit_str
);

   import prsu_pkg::*;

   logic                  v2_ff, v2_in, v3_ff, v3_in;
   logic [AW-1:0]         idx2_ff, idx3_ff;
   logic [STR_BITS-1:0]   str2_ff, str3_ff;
   logic [COORD_BITS-1:0] dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [SQ_BITS-1:0]    sqx3_ff, sqy3_ff;
   logic [COORD_BITS-1:0] ex, ey;
   logic [COORD_BITS:0]   ddx, ddy, mdx, mdy;
   logic [SQ_BITS:0]      dist_sq;

   assign ex = in_entry[COORD_BITS-1:0];
   assign ey = in_entry[2*COORD_BITS-1:COORD_BITS];

   // Signed differences are one bit wider; their magnitude always fits the
   // coordinate width.
   always_comb begin
      ddx    = {pos_x[COORD_BITS-1], pos_x} - {ex[COORD_BITS-1], ex};
      ddy    = {pos_y[COORD_BITS-1], pos_y} - {ey[COORD_BITS-1], ey};
      mdx    = ddx[COORD_BITS] ? (~ddx + 1'b1) : ddx;
      mdy    = ddy[COORD_BITS] ? (~ddy + 1'b1) : ddy;
      dx2_in = mdx[COORD_BITS-1:0];
      dy2_in = mdy[COORD_BITS-1:0];
      v2_in  = in_valid && !flush;
      v3_in  = v2_ff && !flush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      idx2_ff <= in_idx;
      str2_ff <= in_entry[ENTRY_BITS-1:2*COORD_BITS];
      dx2_ff  <= dx2_in;
      dy2_ff  <= dy2_in;
      idx3_ff <= idx2_ff;
      str3_ff <= str2_ff;
      sqx3_ff <= SQ_BITS'(dx2_ff) * SQ_BITS'(dx2_ff);
      sqy3_ff <= SQ_BITS'(dy2_ff) * SQ_BITS'(dy2_ff);
   end

   assign dist_sq   = {1'b0, sqx3_ff} + {1'b0, sqy3_ff};
   assign stat.hit  = v3_ff && (dist_sq < {1'b0, radius_sq});
   assign stat.busy = v2_ff || v3_ff;
   assign hit_idx   = idx3_ff;
   assign hit_str   = str3_ff;

endmodule

### src/point_radius_suppression_unit.sv
// Flow: a read item passes DISPATCH, READ and DONE; an offer to a full store
// passes DISPATCH and DONE; any other offer passes DISPATCH, SCAN when points
// are kept, then APPEND or DECIDE, and DONE. One item is in work at a time;
// the scan is paced by the single store read port and one compare per cycle.
// Reset clears the point count, the control registers and the handshakes; the
// store contents are left as they are and are never used before being written.
// ----------------------------------------------------------------------------
// point_radius_suppression_unit
// Radius non-maximum suppression over a stream of 2-D points, with a point
// store scanned newest first by a pipelined distance compare.
// ----------------------------------------------------------------------------
module point_radius_suppression_unit #(
   parameter int MAX_POINTS = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pos_x, pos_y, strength, read_index
   input  logic [prsu_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // func, start_new_set
   input  logic [prsu_pkg::REQ_USER_BITS-1:0]    req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // slot, kept_total, out_x, out_y, out_strength, zero pad
   output logic [prsu_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // verdict
   output logic [prsu_pkg::RSP_USER_BITS-1:0]    rsp_tuser,
   input  logic                                  csr_we,
   input  logic [prsu_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [prsu_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   import prsu_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int RW = (CW > IDX_BITS) ? CW : IDX_BITS;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_POINTS);

   prsu_state_type        state_ff, state_in;
   logic [SQ_BITS-1:0]    radius_sq_ff;
   logic                  keep_ff;
   logic [CW-1:0]         count_ff, count_in;

   logic                  func_ff, func_in;
   logic [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic [STR_BITS-1:0]   s_ff, s_in;
   logic [IDX_BITS-1:0]   ridx_ff, ridx_in;

   logic [AW-1:0]         iss_ff, iss_in;
   logic                  iss_more_ff, iss_more_in;
   logic                  v1_ff, v1_in;
   logic [AW-1:0]         idx1_ff, idx1_in;
   logic [AW-1:0]         match_idx_ff, match_idx_in;
   logic [STR_BITS-1:0]   match_str_ff, match_str_in;

   prsu_verdict_type      res_verdict_ff, res_verdict_in;
   logic [IDX_BITS-1:0]   res_slot_ff, res_slot_in;
   logic [COORD_BITS-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [STR_BITS-1:0]   res_s_ff, res_s_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_BITS-1:0] rsp_user_ff, rsp_user_in;

   logic                  wr_en, rd_en, flush;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [ENTRY_BITS-1:0] wr_data, rd_data;
   logic [CW-1:0]         count_m1;
   prsu_dist_stat_type    dist_stat;
   logic [AW-1:0]         hit_idx;
   logic [STR_BITS-1:0]   hit_str;

   prsu_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   prsu_dist #(
      .AW(AW)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .flush     (flush),
      .in_valid  (v1_ff),
      .in_idx    (idx1_ff),
      .in_entry  (rd_data),
      .pos_x     (x_ff),
      .pos_y     (y_ff),
      .radius_sq (radius_sq_ff),
      .stat      (dist_stat),
      .hit_idx   (hit_idx),
      .hit_str   (hit_str)
   );

   assign count_m1 = count_ff - 1'b1;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      func_in        = func_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      s_in           = s_ff;
      ridx_in        = ridx_ff;
      iss_in         = iss_ff;
      iss_more_in    = iss_more_ff;
      v1_in          = 1'b0;
      idx1_in        = idx1_ff;
      match_idx_in   = match_idx_ff;
      match_str_in   = match_str_ff;
      res_verdict_in = res_verdict_ff;
      res_slot_in    = res_slot_ff;
      res_x_in       = res_x_ff;
      res_y_in       = res_y_ff;
      res_s_in       = res_s_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      req_tready     = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = AW'(count_ff);
      wr_data        = {s_ff, y_ff, x_ff};
      rd_en          = 1'b0;
      rd_addr        = iss_ff;
      flush          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in = req_tuser[REQ_FUNC_BIT];
               x_in    = req_tdata[REQ_X_LSB +: COORD_BITS];
               y_in    = req_tdata[REQ_Y_LSB +: COORD_BITS];
               s_in    = req_tdata[REQ_S_LSB +: STR_BITS];
               ridx_in = req_tdata[REQ_IDX_LSB +: IDX_BITS];
               if (req_tuser[REQ_START_BIT]) begin
                  count_in = '0;
               end
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            res_x_in = '0;
            res_y_in = '0;
            res_s_in = '0;
            if (func_ff == FUNC_READ) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(ridx_ff);
               state_in = ST_READ;
            end else if (count_ff == MAX_COUNT) begin
               res_verdict_in = VERDICT_FULL;
               res_slot_in    = '0;
               state_in       = ST_DONE;
            end else if (count_ff == '0) begin
               state_in = ST_APPEND;
            end else begin
               iss_in      = count_m1[AW-1:0];
               iss_more_in = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_READ: begin
            res_verdict_in = VERDICT_READ;
            res_slot_in    = ridx_ff;
            // An index at or above the count reads as zeros.
            if (RW'(ridx_ff) < RW'(count_ff)) begin
               res_x_in = rd_data[COORD_BITS-1:0];
               res_y_in = rd_data[2*COORD_BITS-1:COORD_BITS];
               res_s_in = rd_data[ENTRY_BITS-1:2*COORD_BITS];
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            // Entries are issued newest first, so the first hit out of the
            // pipeline is the most recently kept match.
            if (iss_more_ff) begin
               rd_en   = 1'b1;
               rd_addr = iss_ff;
               v1_in   = 1'b1;
               idx1_in = iss_ff;
               if (iss_ff == '0) begin
                  iss_more_in = 1'b0;
               end else begin
                  iss_in = iss_ff - 1'b1;
               end
            end
            if (dist_stat.hit) begin
               match_idx_in = hit_idx;
               match_str_in = hit_str;
               flush        = 1'b1;
               v1_in        = 1'b0;
               iss_more_in  = 1'b0;
               state_in     = ST_DECIDE;
            end else if (!iss_more_ff && !v1_ff && !dist_stat.busy) begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            wr_en          = 1'b1;
            wr_addr        = AW'(count_ff);
            count_in       = count_ff + 1'b1;
            res_verdict_in = VERDICT_APPENDED;
            res_slot_in    = IDX_BITS'(count_ff);
            state_in       = ST_DONE;
         end
         ST_DECIDE: begin
            res_slot_in = IDX_BITS'(match_idx_ff);
            if (keep_ff && (match_str_ff < s_ff)) begin
               wr_en          = 1'b1;
               wr_addr        = match_idx_ff;
               res_verdict_in = VERDICT_REPLACED;
            end else begin
               res_verdict_in = VERDICT_SUPPRESSED;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_verdict_ff;
               rsp_data_in  = {{RSP_PAD_BITS{1'b0}}, res_s_ff, res_y_ff, res_x_ff,
                               TOTAL_BITS'(count_ff), res_slot_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         iss_more_ff  <= 1'b0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         radius_sq_ff <= '0;
         keep_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_more_ff  <= iss_more_in;
         v1_ff        <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_RADIUS: radius_sq_ff <= SQ_BITS'(csr_wdata) * SQ_BITS'(csr_wdata);
               CSR_KEEP:   keep_ff      <= csr_wdata[0];
               default:    keep_ff      <= keep_ff;
            endcase
         end
      end
      func_ff        <= func_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      s_ff           <= s_in;
      ridx_ff        <= ridx_in;
      iss_ff         <= iss_in;
      idx1_ff        <= idx1_in;
      match_idx_ff   <= match_idx_in;
      match_str_ff   <= match_str_in;
      res_verdict_ff <= res_verdict_in;
      res_slot_ff    <= res_slot_in;
      res_x_ff       <= res_x_in;
      res_y_ff       <= res_y_in;
      res_s_ff       <= res_s_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### src/prsu_checker.sv
// ----------------------------------------------------------------------------
// prsu_checker
// Port-level checks on the point radius suppression unit, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prsu_checker #(
   parameter int MAX_POINTS = 256
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [prsu_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [prsu_pkg::RSP_USER_BITS-1:0] rsp_tuser
);

   import prsu_pkg::*;

   localparam logic [TOTAL_BITS-1:0] FULL_TOTAL = TOTAL_BITS'(MAX_POINTS);

   logic [IDX_BITS-1:0]   slot;
   logic [TOTAL_BITS-1:0] total;
   logic [IDX_BITS-1:0]   slot_next;

   assign slot      = rsp_tdata[RSP_SLOT_LSB +: IDX_BITS];
   assign total     = rsp_tdata[RSP_TOTAL_LSB +: TOTAL_BITS];
   assign slot_next = slot + 1'b1;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPL(a_full_total, clock, reset, rsp_tvalid && (rsp_tuser == VERDICT_FULL), (slot == '0) && (total == FULL_TOTAL))
   `ASSERT_IMPL(a_append_total, clock, reset, rsp_tvalid && (rsp_tuser == VERDICT_APPENDED), slot_next == total[IDX_BITS-1:0])
   `ASSERT_IMPL(a_zero_payload, clock, reset, rsp_tvalid && (rsp_tuser != VERDICT_READ), rsp_tdata[RSP_S_MSB:RSP_X_LSB] == '0)

endmodule

bind point_radius_suppression_unit prsu_checker #(.MAX_POINTS(MAX_POINTS)) u_prsu_checker (.*);
